// ===== rtl/core/kvt_pkg.sv =====
// shared constants, codes and types for the key/value table
package kvt_pkg;

   localparam int CAPACITY    = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } kvt_op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2,
      ST_MISS = 2'd3
   } kvt_status_type;

   // per-cycle commands broadcast down the cell row
   typedef struct packed {
      logic compare_en;
      logic shift_en;
      logic load_en;
   } kvt_ctl_type;

endpackage

// ===== rtl/core/kvt_cell.sv =====
// one storage cell of the table: key, value, match flag and shift path
module kvt_cell
   import kvt_pkg::*;
(
   input  logic                   clock,
   input  kvt_ctl_type            ctl,
   input  logic [IDX_W-1:0]       cell_index,
   input  logic [CNT_W-1:0]       count,
   input  logic [KEY_WIDTH-1:0]   cmp_key,
   input  logic [VALUE_WIDTH-1:0] cmp_value,
   input  logic [KEY_WIDTH-1:0]   next_key,
   input  logic [VALUE_WIDTH-1:0] next_value,
   output logic [KEY_WIDTH-1:0]   key_out,
   output logic [VALUE_WIDTH-1:0] value_out,
   input  logic                   hit_in,
   output logic                   hit_out,
   input  logic [VALUE_WIDTH-1:0] rd_in,
   output logic [VALUE_WIDTH-1:0] rd_out
);

   logic [KEY_WIDTH-1:0]   key_ff,   key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   match_ff, match_in;
   logic                   valid;
   logic                   at_tail;

   assign valid   = {1'b0, cell_index} < count;
   assign at_tail = {1'b0, cell_index} == count;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      match_in = match_ff;
      if (ctl.compare_en) begin
         match_in = valid && (key_ff == cmp_key);
      end
      // a hit at or below this cell pulls the upper neighbor down
      if (ctl.shift_en && hit_out) begin
         key_in   = next_key;
         value_in = next_value;
      end else if (ctl.load_en && at_tail) begin
         key_in   = cmp_key;
         value_in = cmp_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;
   assign hit_out   = hit_in | match_ff;
   assign rd_out    = rd_in | (match_ff ? value_ff : '0);

endmodule

// ===== rtl/core/key_value_table.sv =====
// top level of the key/value table: control sequencer and the cell row
//
// usage
//  - request channel: drive start with req_type, req_key and req_value; the
//    transfer happens at a rising edge where start is high and busy is low
//  - operations: insert appends a new key/value, remove deletes a key and
//    closes the gap, lookup returns the stored value, clear empties the table
//  - result channel: rsp_strobe is high for exactly one cycle per request and
//    carries rsp_status, rsp_found, rsp_read_value and rsp_entry_count; the
//    receiver cannot stall, so it must take every result in that cycle
//  - sequence: after the request transfer the compare step registers the match
//    flags, then the apply step updates the row and registers the result
//  - overlap: a request may transfer in the prior one's apply step; busy is
//    high only during the compare step of the compare-then-apply sequence
//  - the row of cells compares every stored key at once; a remove shifts all
//    entries above the hit down one cell in the same apply step
//  - reset: synchronous, clears the entry count, sequencer and result; key and
//    value storage is not cleared, entries above the count are never used
//  - no clearing pass: the block takes requests right after reset
module key_value_table
   import kvt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_type,
   input  logic [KEY_WIDTH-1:0]   req_key,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic                   rsp_found,
   output logic [VALUE_WIDTH-1:0] rsp_read_value,
   output logic [CNT_W-1:0]       rsp_entry_count
);

   typedef enum logic [1:0] {
      IDLE,
      COMPARE,
      APPLY
   } state_type;

   state_type              state_ff;
   logic                   busy_ff;
   logic [CNT_W-1:0]       count_ff;

   // request held for the compare and apply steps
   kvt_op_type             op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;

   // registered result
   logic                   rsp_strobe_ff;
   kvt_status_type         rsp_status_ff;
   logic                   rsp_found_ff;
   logic [VALUE_WIDTH-1:0] rsp_read_value_ff;

   logic                   accept;
   logic                   full;
   logic                   any_hit;
   kvt_ctl_type            ctl;

   // neighbor links along the row
   logic [KEY_WIDTH-1:0]   key_link   [CAPACITY+1];
   logic [VALUE_WIDTH-1:0] value_link [CAPACITY+1];
   logic                   hit_link   [CAPACITY+1];
   logic [VALUE_WIDTH-1:0] rd_link    [CAPACITY+1];

   assign accept  = start && !busy_ff;
   assign full    = count_ff == CNT_W'(CAPACITY);
   assign any_hit = hit_link[CAPACITY];

   always_comb begin
      ctl            = '0;
      ctl.compare_en = state_ff == COMPARE;
      ctl.shift_en   = (state_ff == APPLY) && (op_ff == OP_REMOVE);
      // insert only when the key is new and there is room
      ctl.load_en    = (state_ff == APPLY) && (op_ff == OP_INSERT) && !any_hit && !full;
   end

   // chain ends: nothing above the top cell, nothing below the bottom one
   assign key_link[CAPACITY]   = '0;
   assign value_link[CAPACITY] = '0;
   assign hit_link[0]          = 1'b0;
   assign rd_link[0]           = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      kvt_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_index (IDX_W'(i)),
         .count      (count_ff),
         .cmp_key    (key_ff),
         .cmp_value  (value_ff),
         .next_key   (key_link[i+1]),
         .next_value (value_link[i+1]),
         .key_out    (key_link[i]),
         .value_out  (value_link[i]),
         .hit_in     (hit_link[i]),
         .hit_out    (hit_link[i+1]),
         .rd_in      (rd_link[i]),
         .rd_out     (rd_link[i+1])
      );
   end

   // request capture, payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= kvt_op_type'(req_type);
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // sequencer, entry count and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= IDLE;
         busy_ff           <= 1'b0;
         count_ff          <= '0;
         rsp_strobe_ff     <= 1'b0;
         rsp_status_ff     <= ST_OK;
         rsp_found_ff      <= 1'b0;
         rsp_read_value_ff <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= COMPARE;
                  busy_ff  <= 1'b1;
               end
            end
            COMPARE: begin
               state_ff <= APPLY;
               busy_ff  <= 1'b0;
            end
            APPLY: begin
               // a new request may overlap the apply step
               if (accept) begin
                  state_ff <= COMPARE;
                  busy_ff  <= 1'b1;
               end else begin
                  state_ff <= IDLE;
               end
               rsp_strobe_ff     <= 1'b1;
               rsp_status_ff     <= ST_OK;
               rsp_found_ff      <= 1'b0;
               rsp_read_value_ff <= '0;
               unique case (op_ff)
                  OP_INSERT: begin
                     if (any_hit) begin
                        rsp_status_ff <= ST_DUP;
                     end else if (full) begin
                        rsp_status_ff <= ST_FULL;
                     end else begin
                        count_ff <= count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (any_hit) begin
                        rsp_found_ff <= 1'b1;
                        count_ff     <= count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_ff <= ST_MISS;
                     end
                  end
                  OP_LOOKUP: begin
                     if (any_hit) begin
                        rsp_found_ff      <= 1'b1;
                        rsp_read_value_ff <= rd_link[CAPACITY];
                     end else begin
                        rsp_status_ff <= ST_MISS;
                     end
                  end
                  OP_CLEAR: begin
                     count_ff <= '0;
                  end
                  default: begin
                     rsp_status_ff <= ST_OK;
                  end
               endcase
            end
            default: begin
               state_ff <= IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy            = busy_ff;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   // count changes only on the apply edge, so it matches the result it goes with
   assign rsp_entry_count = count_ff;

endmodule

// ===== rtl/core/kvt_checker.sv =====
// port-level checks for the key/value table and their bind
module kvt_checker
   import kvt_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input logic [1:0]             rsp_status,
   input logic                   rsp_found,
   input logic [VALUE_WIDTH-1:0] rsp_read_value,
   input logic [CNT_W-1:0]       rsp_entry_count
);

   // each transfer gets its result after its compare step and its apply step
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##2 rsp_strobe)
      else $error("no result in the cycle after the second edge past a request transfer");

   // busy covers the compare step only
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held for more than one cycle");

   // no result without a request before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy, 2))
      else $error("result without a request transfer");

   // a hit always reports ok, and the count stays in range
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |->
         (rsp_status == ST_OK) && (rsp_entry_count <= CNT_W'(CAPACITY)))
      else $error("found result with a bad status or count");

   // a result without a hit never carries a value
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> (rsp_read_value == '0))
      else $error("value returned without a hit");

endmodule

bind key_value_table kvt_checker u_kvt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_found       (rsp_found),
   .rsp_read_value  (rsp_read_value),
   .rsp_entry_count (rsp_entry_count)
);
